/* design/indexed_list_insert_remove_macros.svh */
// Assertion macros for the indexed list block.
// Used by indexed_list_insert_remove.sv; expects clk_i and rst_ni in scope.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

// same-cycle implication
`define ILIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ilir_pkg.sv */
// Shared types and constants for the indexed list block.
// No dependencies; imported by indexed_list_insert_remove.
package ilir_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  // signed width for request positions: index minus base, and against the count
  localparam int POS_W      = (CW + 1 > 17) ? CW + 1 : 17;

  localparam int IDX_W      = 16;
  localparam int VAL_W      = 32;
  localparam int COUNT_W    = 11;

  typedef enum logic [2:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_REM_LAST  = 3'd2,
    REQ_REM_AT    = 3'd3,
    REQ_REM_RANGE = 3'd4,
    REQ_READ      = 3'd5,
    REQ_WRITE     = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

/* design/indexed_list_insert_remove.sv */
// Indexed list with insert and remove over one synchronous entry memory.
// Depends on ilir_pkg and indexed_list_insert_remove_macros.svh.
//
//  channel   direction  signals                             moves
//  s_axis    in         tvalid tready tdata[63:0] tuser[2:0]  one request
//  m_axis    out        tvalid tready tdata[47:0] tuser[1:0]  one result
//  cfg       in         cfg_valid_i cfg_ready_o cfg_data_i    index_base write
//
// Insert and remove at/range move entries through the single memory read port, one
// entry per cycle. One request at a time; the next is taken once the result is parked
// in the output register, even while that register waits for m_axis_tready.
// Reset clears the state, count, base, pending write and output valid; the memory is not cleared.
`include "indexed_list_insert_remove_macros.svh"

module indexed_list_insert_remove
  import ilir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // index[15:0], index_last[31:16], value[63:32]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // read_data[31:0], item_count[42:32], zero[47:43]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i     // index_base
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SHIFT, S_DRAIN, S_PUT, S_RD_WAIT, S_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [IDX_W-1:0]        base_q, base_d;
  logic                    pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;

  req_e                    req_q;
  logic signed [POS_W-1:0] pos_q, last_q;
  logic [DATA_WIDTH-1:0]   val_q;
  logic [CW-1:0]           ptr_q, ptr_d, stop_q, stop_d, gap_q, gap_d;
  logic                    up_q, up_d;
  logic [AW-1:0]           wr_addr_q, wr_addr_d;
  status_e                 res_status_q, res_status_d;
  logic [VAL_W-1:0]        res_data_q, res_data_d;
  status_e                 out_status_q;
  logic [VAL_W-1:0]        out_data_q;
  logic [COUNT_W-1:0]      out_count_q;

  logic [DATA_WIDTH-1:0]   mem [DEPTH];
  logic [DATA_WIDTH-1:0]   mem_rdata_q;
  logic                    mem_re, dir_we, mem_we;
  logic [AW-1:0]           mem_raddr, dir_waddr, mem_waddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;

  logic                    in_xfer, out_load;
  logic signed [POS_W-1:0] cnt_x;
  logic                    pos_neg, pos_gt, pos_ge, last_lt, last_gt, full, empty;
  logic [CW-1:0]           pos_c, rng_last, rng_gap;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  // position checks against the current count
  assign cnt_x    = $signed({{(POS_W - CW){1'b0}}, cnt_q});
  assign pos_neg  = pos_q[POS_W-1];
  assign pos_gt   = pos_q > cnt_x;
  assign pos_ge   = pos_q >= cnt_x;
  assign last_lt  = last_q < pos_q;
  assign last_gt  = last_q > cnt_x;
  assign full     = (cnt_q == CW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign pos_c    = pos_q[CW-1:0];
  assign rng_last = (req_q == REQ_REM_AT) ? pos_c + CW'(1) : last_q[CW-1:0];
  assign rng_gap  = rng_last - pos_c;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    pend_d       = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    ptr_d        = ptr_q;
    stop_d       = stop_q;
    gap_d        = gap_q;
    up_d         = up_q;
    wr_addr_d    = wr_addr_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[AW-1:0];
    dir_we       = 1'b0;
    dir_waddr    = pos_c[AW-1:0];

    if (cfg_valid_i) begin
      base_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_status_d = ST_OK;
        res_data_d   = '0;
        state_d      = S_FIN;
        case (req_q)
          REQ_APPEND: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              dir_we    = 1'b1;
              dir_waddr = cnt_q[AW-1:0];
              cnt_d     = cnt_q + CW'(1);
            end
          end
          REQ_INSERT: begin
            if (pos_neg || pos_gt) begin
              res_status_d = ST_RANGE;
            end else if (full) begin
              res_status_d = ST_FULL;
            end else if (pos_c == cnt_q) begin
              dir_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
            end else begin
              // move entries up, highest first
              ptr_d   = cnt_q - CW'(1);
              stop_d  = pos_c;
              up_d    = 1'b1;
              state_d = S_SHIFT;
            end
          end
          REQ_REM_LAST: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          REQ_REM_AT, REQ_REM_RANGE: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else if (pos_neg || ((req_q == REQ_REM_AT) ? pos_ge : (last_lt || last_gt)))
            begin
              res_status_d = ST_RANGE;
            end else if (rng_last == cnt_q) begin
              cnt_d = cnt_q - rng_gap;
            end else if (rng_gap != '0) begin
              // move the tail down, lowest first
              ptr_d   = rng_last;
              stop_d  = cnt_q - CW'(1);
              gap_d   = rng_gap;
              up_d    = 1'b0;
              state_d = S_SHIFT;
            end
          end
          REQ_READ: begin
            if (pos_neg || pos_ge) begin
              res_status_d = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = pos_c[AW-1:0];
              state_d   = S_RD_WAIT;
            end
          end
          REQ_WRITE: begin
            if (pos_neg || pos_ge) begin
              res_status_d = ST_RANGE;
            end else begin
              dir_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        // read one entry; it is written back next cycle at its new place
        mem_re    = 1'b1;
        pend_d    = 1'b1;
        wr_addr_d = up_q ? AW'(ptr_q + CW'(1)) : AW'(ptr_q - gap_q);
        if (ptr_q == stop_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = up_q ? ptr_q - CW'(1) : ptr_q + CW'(1);
        end
      end
      S_DRAIN: begin
        if (up_q) begin
          state_d = S_PUT;
        end else begin
          cnt_d   = cnt_q - gap_q;
          state_d = S_FIN;
        end
      end
      S_PUT: begin
        dir_we  = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_FIN;
      end
      S_RD_WAIT: begin
        res_data_d = VAL_W'(mem_rdata_q);
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // pending shift write has priority; the sequencer never overlaps it with a direct write
  assign mem_we    = pend_q || dir_we;
  assign mem_waddr = pend_q ? wr_addr_q : dir_waddr;
  assign mem_wdata = pend_q ? mem_rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      base_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q  <= req_e'(s_axis_tuser);
      pos_q  <= $signed({{(POS_W - IDX_W){s_axis_tdata[15]}}, s_axis_tdata[15:0]})
              - $signed({{(POS_W - IDX_W){base_q[IDX_W-1]}}, base_q});
      last_q <= $signed({{(POS_W - IDX_W){s_axis_tdata[31]}}, s_axis_tdata[31:16]})
              - $signed({{(POS_W - IDX_W){base_q[IDX_W-1]}}, base_q});
      val_q  <= DATA_WIDTH'(s_axis_tdata[63:32]);
    end
    ptr_q        <= ptr_d;
    stop_q       <= stop_d;
    gap_q        <= gap_d;
    up_q         <= up_d;
    wr_addr_q    <= wr_addr_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_count_q  <= COUNT_W'(cnt_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_count_q, out_data_q};
  assign m_axis_tuser  = out_status_q;

  `ILIR_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CW'(DEPTH), "entry count above depth")
  `ILIR_ASSERT_NOW(a_pend_in_shift, pend_q, (state_q == S_SHIFT) || (state_q == S_DRAIN),
    "shift write pending outside shift")
  `ILIR_ASSERT_NEXT(a_xfer_check, in_xfer, state_q == S_CHECK, "request not decoded")

endmodule
